// File: rtl/core/htc_pkg.sv
// Types and constants shared by the humidity/temperature calibration block.
package htc_pkg;

   localparam int CNT_W      = 16;  // raw counts and calibration counts
   localparam int PT_W       = 7;   // calibration points in degrees or percent
   localparam int RES_W      = 16;  // result fields
   localparam int QUOT_W     = 23;  // |(x - x0) * (y1 - y0)| < 2**23
   localparam int LANE_LAT   = QUOT_W + 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_TEMP_LOW_DEG    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_HIGH_DEG   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_LOW_COUNT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_HIGH_COUNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HUM_LOW_PCT     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HUM_HIGH_PCT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HUM_LOW_COUNT   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_HUM_HIGH_COUNT  = 3'd7;

   typedef struct packed {
      logic signed [CNT_W-1:0] raw_temp;
      logic signed [CNT_W-1:0] raw_hum;
   } req_type;

   typedef struct packed {
      logic signed [RES_W-1:0] temp_deg;
      logic        [RES_W-1:0] hum_pct;
      logic                    temp_div_zero;
      logic                    hum_div_zero;
   } rsp_type;

   // One straight line: counts x0, x1 map to points y0, y1.
   typedef struct packed {
      logic signed [CNT_W-1:0] x0;
      logic signed [CNT_W-1:0] x1;
      logic        [PT_W-1:0]  y0;
      logic        [PT_W-1:0]  y1;
   } cal_type;

endpackage

// File: rtl/core/htc_lane.sv
// One calibration channel: subtract, multiply, then a bit-per-stage restoring divider.
module htc_lane
   import htc_pkg::*;
(
   input  logic                    clock,
   input  logic                    adv,
   input  logic signed [CNT_W-1:0] raw,
   input  cal_type                 cal,
   output logic        [RES_W-1:0] result,
   output logic                    div_zero
);

   // calibration-derived values; the user keeps them stable while words are in flight, the block does not enforce it
   logic signed [CNT_W:0]   den_in;
   logic        [CNT_W-1:0] den_abs_ff;
   logic                    den_neg_ff;
   logic                    den_zero_ff;
   logic signed [PT_W:0]    dy_ff;

   assign den_in = {cal.x1[CNT_W-1], cal.x1} - {cal.x0[CNT_W-1], cal.x0};

   always_ff @(posedge clock) begin
      den_abs_ff  <= den_in[CNT_W] ? CNT_W'(-den_in) : den_in[CNT_W-1:0];
      den_neg_ff  <= den_in[CNT_W];
      den_zero_ff <= (den_in == '0);
      dy_ff       <= $signed({1'b0, cal.y1}) - $signed({1'b0, cal.y0});
   end

   // front stages
   logic signed [CNT_W:0]      diff_ff;
   logic signed [CNT_W+PT_W:0] prod_ff;
   logic signed [CNT_W+PT_W:0] prod_in;

   assign prod_in = (CNT_W+PT_W+1)'(diff_ff) * (CNT_W+PT_W+1)'(dy_ff);

   // divider stages; entry 0 is loaded from the product
   logic [CNT_W-1:0]  rem_ff [QUOT_W+1];
   logic [QUOT_W-1:0] nq_ff  [QUOT_W+1];
   logic              neg_ff [QUOT_W+1];
   logic [CNT_W-1:0]  rem_in [QUOT_W+1];
   logic [QUOT_W-1:0] nq_in  [QUOT_W+1];

   always_comb begin
      logic [CNT_W:0] trial;
      logic           fits;
      rem_in[0] = '0;
      nq_in[0]  = prod_ff[CNT_W+PT_W] ? QUOT_W'(-prod_ff) : prod_ff[QUOT_W-1:0];
      for (int k = 1; k <= QUOT_W; k++) begin
         trial     = {rem_ff[k-1], nq_ff[k-1][QUOT_W-1]};
         fits      = (trial >= {1'b0, den_abs_ff});
         rem_in[k] = fits ? CNT_W'(trial - {1'b0, den_abs_ff}) : trial[CNT_W-1:0];
         nq_in[k]  = {nq_ff[k-1][QUOT_W-2:0], fits};
      end
   end

   // apply sign on the low bits, then add the base point
   logic [RES_W-1:0] qlo;
   logic [RES_W-1:0] sq;
   logic [RES_W-1:0] res_ff;
   logic             zero_ff;

   assign qlo = nq_ff[QUOT_W][RES_W-1:0];
   assign sq  = neg_ff[QUOT_W] ? (~qlo + RES_W'(1)) : qlo;

   always_ff @(posedge clock) begin
      if (adv) begin
         diff_ff   <= {raw[CNT_W-1], raw} - {cal.x0[CNT_W-1], cal.x0};
         prod_ff   <= prod_in;
         neg_ff[0] <= prod_ff[CNT_W+PT_W] ^ den_neg_ff;
         for (int k = 0; k <= QUOT_W; k++) begin
            rem_ff[k] <= rem_in[k];
            nq_ff[k]  <= nq_in[k];
         end
         for (int k = 1; k <= QUOT_W; k++) begin
            neg_ff[k] <= neg_ff[k-1];
         end
         res_ff  <= den_zero_ff ? '0 : sq + {{(RES_W-PT_W){1'b0}}, cal.y0};
         zero_ff <= den_zero_ff;
      end
   end

   assign result   = res_ff;
   assign div_zero = zero_ff;

endmodule

// File: rtl/core/humidity_temp_calibration.sv
// Top level: calibration registers, valid pipeline and the two calibration lanes.
//
//   port group   dir   handshake             carries
//   req_         in    req_valid/req_ready   req_type: raw_temp, raw_hum
//   rsp_         out   rsp_valid/rsp_ready   rsp_type: temp_deg, hum_pct, flags
//   csr_         in    csr_wen (no wait)     csr_index, csr_wdata
//
// One word per cycle enters while the output is not stalled; the 23-stage restoring
// divider sits behind the subtract, multiply and magnitude stages and ahead of the
// sign and offset stage.
// Reset clears the valid pipeline and all calibration registers to zero.
// A stalled output freezes the whole pipeline; req_ready drops for the same cycle.
module humidity_temp_calibration
   import htc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cal_type temp_cal_ff;
   cal_type hum_cal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff <= '0;
         hum_cal_ff  <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_TEMP_LOW_DEG:    temp_cal_ff.y0 <= csr_wdata[PT_W-1:0];
            REG_TEMP_HIGH_DEG:   temp_cal_ff.y1 <= csr_wdata[PT_W-1:0];
            REG_TEMP_LOW_COUNT:  temp_cal_ff.x0 <= csr_wdata[CNT_W-1:0];
            REG_TEMP_HIGH_COUNT: temp_cal_ff.x1 <= csr_wdata[CNT_W-1:0];
            REG_HUM_LOW_PCT:     hum_cal_ff.y0  <= csr_wdata[PT_W-1:0];
            REG_HUM_HIGH_PCT:    hum_cal_ff.y1  <= csr_wdata[PT_W-1:0];
            REG_HUM_LOW_COUNT:   hum_cal_ff.x0  <= csr_wdata[CNT_W-1:0];
            REG_HUM_HIGH_COUNT:  hum_cal_ff.x1  <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // advance everything unless a finished word is waiting
   logic                adv;
   logic [LANE_LAT-1:0] vld_ff;

   assign adv       = !vld_ff[LANE_LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[LANE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LANE_LAT-2:0], req_valid};
      end
   end

   logic [RES_W-1:0] temp_res;
   logic [RES_W-1:0] hum_res;
   logic             temp_zero;
   logic             hum_zero;

   htc_lane u_temp (
      .clock    (clock),
      .adv      (adv),
      .raw      (req_data.raw_temp),
      .cal      (temp_cal_ff),
      .result   (temp_res),
      .div_zero (temp_zero)
   );

   htc_lane u_hum (
      .clock    (clock),
      .adv      (adv),
      .raw      (req_data.raw_hum),
      .cal      (hum_cal_ff),
      .result   (hum_res),
      .div_zero (hum_zero)
   );

   always_comb begin
      rsp_data               = '0;
      rsp_data.temp_deg      = $signed(temp_res);
      rsp_data.hum_pct       = hum_res;
      rsp_data.temp_div_zero = temp_zero;
      rsp_data.hum_div_zero  = hum_zero;
   end

   a_temp_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.temp_div_zero == (temp_cal_ff.x0 == temp_cal_ff.x1))
      else $error("temperature divide-by-zero flag disagrees with calibration");

   a_hum_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.hum_div_zero == (hum_cal_ff.x0 == hum_cal_ff.x1))
      else $error("humidity divide-by-zero flag disagrees with calibration");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.temp_div_zero |-> rsp_data.temp_deg == '0)
      else $error("temperature result not zero on divide by zero");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(vld_ff))
      else $error("pipeline moved while output stalled");

endmodule
